[rtl/core/sacache_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacache_pkg
// Shared constants and types of the set-associative cache controller.
// ----------------------------------------------------------------------------
package sacache_pkg;
	localparam int SETS      = 256;
	localparam int WAYS      = 8;
	localparam int ADDR_BITS = 48;
	localparam int SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int CNT_W     = $clog2(WAYS + 1);
	localparam int MAX_IB    = $clog2(SETS);
	localparam int LRU_W     = WAYS * WAY_W;

	typedef logic [1:0] status_t;
	localparam status_t ST_HIT     = 2'd0;
	localparam status_t ST_MISS    = 2'd1;
	localparam status_t ST_BUSY    = 2'd2;
	localparam status_t ST_RELEASE = 2'd3;

	localparam logic [1:0] REG_OFFSET = 2'd0;
	localparam logic [1:0] REG_INDEX  = 2'd1;
	localparam logic [1:0] REG_WAYS   = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOKUP,
		S_OUT
	} ctl_state_t;

	// one way's stored line
	typedef struct packed {
		logic                 valid;
		logic                 dirty;
		logic [ADDR_BITS-1:0] tag;
	} line_t;

	typedef struct packed {
		logic                 command;
		logic [47:0]          address;
		logic                 is_write;
		logic [7:0]           release_set;
		logic                 lower_evict_ok;
		logic                 lower_fill_ok;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [2:0]  way;
		logic        allocated;
		logic        evict_issued;
		logic        evict_is_write;
		logic [47:0] evict_address;
		logic [47:0] fill_address;
	} rsp_t;

	typedef struct packed {
		logic [3:0] offset_bits;
		logic [3:0] index_bits;
		logic [3:0] ways_in_use;
	} cfg_t;
endpackage

[rtl/core/sacache_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacache_if
// Valid/ready channels: item, result and configuration write.
// ----------------------------------------------------------------------------
interface sacache_req_if;
	logic                  valid;
	logic                  ready;
	sacache_pkg::req_t     data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface sacache_rsp_if;
	logic                  valid;
	logic                  ready;
	sacache_pkg::rsp_t     data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface sacache_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [3:0]  wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink   (input valid, input index, input wdata, output ready);
endinterface

[rtl/core/set_assoc_writeback_cache_lru.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_writeback_cache_lru
// Tag and true-LRU controller of a set-associative write-back cache.
// ----------------------------------------------------------------------------
// An access reads the set at accept from a synchronous memory with a
// registered read holding tags, valid, dirty and LRU order of all ways;
// hit search and update are then written back in the next cycle (the lookup
// state), and the result is held in an output register. A release item's
// result is registered at accept and offered in the cycle after. One item is
// in work at a time; the next is taken once the result beat has left.
// No clearing pass is needed after reset.
module set_assoc_writeback_cache_lru (
	input  logic        clk,
	input  logic        arst_n,
	sacache_req_if.sink   req,
	sacache_rsp_if.source rsp,
	sacache_cfg_if.sink   cfg
);
	import sacache_pkg::*;

	ctl_state_t state_q, state_d;
	cfg_t       cfg_q;
	req_t       req_q;
	rsp_t       rsp_q;
	logic [SETS-1:0]      busy_q;
	logic [SET_W-1:0]     set_q;
	logic [ADDR_BITS-1:0] blk_q;
	logic [3:0]           off;
	logic [3:0]           ib;
	logic [CNT_W-1:0]     nways;
	logic [ADDR_BITS-1:0] blk;
	logic [ADDR_BITS-1:0] set_mask;
	logic                 acc;
	logic                 rd_en;
	line_t [WAYS-1:0]     rd_lines;
	line_t [WAYS-1:0]     new_lines;
	logic [LRU_W-1:0]     rd_lru;
	logic [LRU_W-1:0]     new_lru;
	logic                 wr_en;
	logic                 pol_busy;
	rsp_t                 pol_rsp;

	// register clamps and address split
	always_comb begin
		off   = (cfg_q.offset_bits > 4'd12) ? 4'd12 : cfg_q.offset_bits;
		ib    = (cfg_q.index_bits > 4'(MAX_IB)) ? 4'(MAX_IB) : cfg_q.index_bits;
		nways = (cfg_q.ways_in_use == 4'd0) ? CNT_W'(1) :
			((cfg_q.ways_in_use > 4'(WAYS)) ? CNT_W'(WAYS) : CNT_W'(cfg_q.ways_in_use));
		blk      = ADDR_BITS'(req.data.address) >> off;
		set_mask = ~({ADDR_BITS{1'b1}} << ib);
	end

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == S_IDLE);
	assign acc       = req.valid && req.ready;
	assign rd_en     = acc && !req.data.command;
	assign rsp.valid = (state_q == S_OUT);
	assign rsp.data  = rsp_q;

	sacache_tag_ram u_ram (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (rd_en),
		.rd_set   (SET_W'(blk & set_mask)),
		.rd_lines (rd_lines),
		.rd_lru   (rd_lru),
		.wr_en    (wr_en && state_q == S_LOOKUP && !busy_q[set_q]),
		.wr_set   (set_q),
		.wr_lines (new_lines),
		.wr_lru   (new_lru)
	);

	sacache_policy u_pol (
		.req       (req_q),
		.off       (off),
		.nways     (nways),
		.blk       (blk_q),
		.lines     (rd_lines),
		.lru       (rd_lru),
		.wr_en     (wr_en),
		.new_lines (new_lines),
		.new_lru   (new_lru),
		.set_busy  (pol_busy),
		.rsp       (pol_rsp)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (acc) state_d = req.data.command ? S_OUT : S_LOOKUP;
			S_LOOKUP: state_d = S_OUT;
			S_OUT:    if (rsp.ready) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// control state, config and busy marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cfg_q   <= '{offset_bits: 4'd6, index_bits: 4'd8, ways_in_use: 4'd8};
			busy_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				case (cfg.index)
					REG_OFFSET: cfg_q.offset_bits <= cfg.wdata;
					REG_INDEX:  cfg_q.index_bits  <= cfg.wdata;
					REG_WAYS:   cfg_q.ways_in_use <= cfg.wdata;
					default:    ;
				endcase
			end
			if (acc && req.data.command && 32'(req.data.release_set) < SETS)
				busy_q[SET_W'(req.data.release_set)] <= 1'b0;
			if (state_q == S_LOOKUP && !busy_q[set_q] && pol_busy)
				busy_q[set_q] <= 1'b1;
		end
	end

	// item capture and result register
	always_ff @(posedge clk) begin
		if (acc) begin
			req_q <= req.data;
			blk_q <= blk;
			set_q <= SET_W'(blk & set_mask);
			if (req.data.command)
				rsp_q <= '{status: ST_RELEASE, default: '0};
		end
		if (state_q == S_LOOKUP) begin
			if (busy_q[set_q]) begin
				rsp_q <= '{status: ST_BUSY, default: '0};
			end else begin
				rsp_q <= pol_rsp;
			end
		end
	end
endmodule

[rtl/core/sacache_tag_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacache_tag_ram
// Per-set memory of all ways' tag, valid and dirty, plus LRU order, with
// a valid bit per set so that unwritten sets read as reset.
// ----------------------------------------------------------------------------
module sacache_tag_ram (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   rd_en,
	input  logic [sacache_pkg::SET_W-1:0]          rd_set,
	output sacache_pkg::line_t [sacache_pkg::WAYS-1:0] rd_lines,
	output logic [sacache_pkg::LRU_W-1:0]          rd_lru,
	input  logic                                   wr_en,
	input  logic [sacache_pkg::SET_W-1:0]          wr_set,
	input  sacache_pkg::line_t [sacache_pkg::WAYS-1:0] wr_lines,
	input  logic [sacache_pkg::LRU_W-1:0]          wr_lru
);
	import sacache_pkg::*;

	line_t [WAYS-1:0] line_mem [SETS];
	logic [LRU_W-1:0] lru_mem [SETS];
	logic [SETS-1:0]  set_ok_q;
	line_t [WAYS-1:0] rdl_q;
	logic [LRU_W-1:0] rdr_q;
	logic             rd_ok_q;
	logic [LRU_W-1:0] lru_init;
	line_t [WAYS-1:0] lines_init;

	// reset order: way 0 most recent
	always_comb begin
		for (int i = 0; i < WAYS; i++) begin
			lru_init[i*WAY_W +: WAY_W] = WAY_W'(i);
			lines_init[i] = '0;
		end
	end

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			line_mem[wr_set] <= wr_lines;
			lru_mem[wr_set]  <= wr_lru;
		end
		if (rd_en) begin
			rdl_q <= line_mem[rd_set];
			rdr_q <= lru_mem[rd_set];
		end
	end

	// per-set written marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_ok_q <= '0;
			rd_ok_q  <= 1'b0;
		end else begin
			if (wr_en)
				set_ok_q[wr_set] <= 1'b1;
			if (rd_en)
				rd_ok_q <= set_ok_q[rd_set];
		end
	end

	assign rd_lines = rd_ok_q ? rdl_q : lines_init;
	assign rd_lru   = rd_ok_q ? rdr_q : lru_init;
endmodule

[rtl/core/sacache_policy.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacache_policy
// Hit search, victim choice, LRU update and result forming for one set.
// ----------------------------------------------------------------------------
module sacache_policy (
	input  sacache_pkg::req_t                      req,
	input  logic [3:0]                             off,
	input  logic [sacache_pkg::CNT_W-1:0]          nways,
	input  logic [sacache_pkg::ADDR_BITS-1:0]      blk,
	input  sacache_pkg::line_t [sacache_pkg::WAYS-1:0] lines,
	input  logic [sacache_pkg::LRU_W-1:0]          lru,
	output logic                                   wr_en,
	output sacache_pkg::line_t [sacache_pkg::WAYS-1:0] new_lines,
	output logic [sacache_pkg::LRU_W-1:0]          new_lru,
	output logic                                   set_busy,
	output sacache_pkg::rsp_t                      rsp
);
	import sacache_pkg::*;

	logic             hit;
	logic [WAY_W-1:0] hw;
	logic [WAY_W-1:0] vw;
	logic [WAY_W-1:0] tw;
	logic             touch;
	logic             pass;
	logic [WAY_W-1:0] prev;
	logic [WAY_W-1:0] cur;
	logic [ADDR_BITS-1:0] ea;
	logic [ADDR_BITS-1:0] fa;

	always_comb begin
		hit = 1'b0;
		hw  = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (CNT_W'(i) < nways && lines[i].valid && lines[i].tag == blk) begin
				hit = 1'b1;
				hw  = WAY_W'(i);
			end
		end
		vw = '0;
		for (int i = 0; i < WAYS; i++) begin
			if (CNT_W'(lru[i*WAY_W +: WAY_W]) < nways)
				vw = lru[i*WAY_W +: WAY_W];
		end
		ea = lines[vw].tag << off;
		fa = blk << off;

		new_lines = lines;
		wr_en     = 1'b0;
		touch     = 1'b0;
		tw        = hw;
		set_busy  = 1'b0;
		rsp       = '0;
		if (hit) begin
			wr_en     = 1'b1;
			touch     = 1'b1;
			if (req.is_write)
				new_lines[hw].dirty = 1'b1;
			rsp.status = ST_HIT;
			rsp.way    = 3'(hw);
		end else begin
			rsp.status = ST_MISS;
			tw = vw;
			if (!lines[vw].valid || req.lower_evict_ok) begin
				if (lines[vw].valid) begin
					wr_en = 1'b1;
					rsp.evict_issued   = 1'b1;
					rsp.evict_is_write = lines[vw].dirty;
					rsp.evict_address  = 48'(ea);
					new_lines[vw].valid = 1'b0;
					new_lines[vw].dirty = 1'b0;
				end
				if (req.lower_fill_ok) begin
					wr_en = 1'b1;
					touch = 1'b1;
					set_busy = 1'b1;
					new_lines[vw].valid = 1'b1;
					new_lines[vw].dirty = req.is_write;
					new_lines[vw].tag   = blk;
					rsp.way          = 3'(vw);
					rsp.allocated    = 1'b1;
					rsp.fill_address = 48'(fa);
				end
			end
		end

		// shift toward least recent up to the touched way
		new_lru = lru;
		prev    = tw;
		pass    = touch;
		for (int i = 0; i < WAYS; i++) begin
			cur = lru[i*WAY_W +: WAY_W];
			if (pass) begin
				new_lru[i*WAY_W +: WAY_W] = prev;
				if (cur == tw)
					pass = 1'b0;
				prev = cur;
			end
		end
	end
endmodule

[verif/set_assoc_writeback_cache_lru_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_writeback_cache_lru_test
// Self-checking test of the set-associative write-back cache controller.
// A behavioral copy of the tags, valid, dirty, LRU order and busy marks
// predicts every result; directed and random accesses run through several
// geometry settings with random gaps on the item and result channels.
// ----------------------------------------------------------------------------
import sacache_pkg::*;

class cache_scoreboard;
	logic [ADDR_BITS-1:0] tags [SETS][WAYS];
	bit                   vld [SETS][WAYS];
	bit                   drt [SETS][WAYS];
	int unsigned          order [SETS][WAYS];
	bit                   busy [SETS];
	int unsigned          off_r, ib_r, ways_r;
	rsp_t                 pending [$];
	int                   errors;
	int                   seen;

	function new();
		for (int s = 0; s < SETS; s++) begin
			busy[s] = 0;
			for (int w = 0; w < WAYS; w++) begin
				vld[s][w] = 0;
				drt[s][w] = 0;
				order[s][w] = w;
				tags[s][w] = '0;
			end
		end
		off_r = 6;
		ib_r = 8;
		ways_r = 8;
		errors = 0;
		seen = 0;
	endfunction

	function void write_reg(logic [1:0] idx, logic [3:0] val);
		if (idx == REG_OFFSET) off_r = 32'(val);
		else if (idx == REG_INDEX) ib_r = 32'(val);
		else if (idx == REG_WAYS) ways_r = 32'(val);
	endfunction

	// append an expected result at the tail
	function void queue_want(rsp_t r);
		pending.insert(pending.size(), r);
	endfunction

	// move way to the front of the set's order
	function void promote(int unsigned s, int unsigned w);
		int unsigned carry, cur;
		carry = w;
		for (int i = 0; i < WAYS; i++) begin
			cur = order[s][i];
			order[s][i] = carry;
			if (cur == w) break;
			carry = cur;
		end
	endfunction

	function void note_item(req_t it);
		rsp_t r;
		int unsigned off, ib, n, s, v, hw;
		logic [ADDR_BITS-1:0] blk;
		bit hit;
		r = '0;
		hit = 0;
		hw = 0;
		if (it.command) begin
			busy[it.release_set] = 0;
			r.status = ST_RELEASE;
			queue_want(r);
			return;
		end
		off = (off_r > 12) ? 12 : off_r;
		ib = (ib_r > MAX_IB) ? MAX_IB : ib_r;
		n = (ways_r < 1) ? 1 : ((ways_r > WAYS) ? WAYS : ways_r);
		blk = it.address >> off;
		s = 32'(blk & ((48'd1 << ib) - 48'd1));
		if (busy[s]) begin
			r.status = ST_BUSY;
			queue_want(r);
			return;
		end
		for (int i = 0; i < n; i++)
			if (!hit && vld[s][i] && tags[s][i] == blk) begin
				hit = 1;
				hw = i;
			end
		if (hit) begin
			promote(s, hw);
			if (it.is_write) drt[s][hw] = 1;
			r.status = ST_HIT;
			r.way = 3'(hw);
			queue_want(r);
			return;
		end
		r.status = ST_MISS;
		v = 0;
		for (int i = WAYS - 1; i >= 0; i--)
			if (order[s][i] < n) begin
				v = order[s][i];
				break;
			end
		if (vld[s][v]) begin
			if (!it.lower_evict_ok) begin
				queue_want(r);
				return;
			end
			r.evict_issued = 1;
			r.evict_is_write = drt[s][v];
			r.evict_address = tags[s][v] << off;
			vld[s][v] = 0;
			drt[s][v] = 0;
		end
		if (it.lower_fill_ok) begin
			tags[s][v] = blk;
			vld[s][v] = 1;
			drt[s][v] = it.is_write;
			busy[s] = 1;
			promote(s, v);
			r.way = 3'(v);
			r.allocated = 1;
			r.fill_address = blk << off;
		end
		queue_want(r);
	endfunction

	task check_result(rsp_t got);
		rsp_t want;
		seen++;
		if (pending.size() == 0) begin
			report_bad($sformatf("unexpected result %p", got));
			return;
		end
		want = pending.pop_front();
		if (got.status !== want.status) report_bad($sformatf("status %0d want %0d",
			got.status, want.status));
		if (got.way !== want.way) report_bad($sformatf("way %0d want %0d",
			got.way, want.way));
		if (got.allocated !== want.allocated) report_bad("allocated mismatch");
		if (got.evict_issued !== want.evict_issued) report_bad("evict_issued mismatch");
		if (got.evict_is_write !== want.evict_is_write) report_bad("evict_is_write mismatch");
		if (got.evict_address !== want.evict_address)
			report_bad($sformatf("evict_address %h want %h", got.evict_address,
				want.evict_address));
		if (got.fill_address !== want.fill_address)
			report_bad($sformatf("fill_address %h want %h", got.fill_address,
				want.fill_address));
	endtask

	task report_bad(string msg);
		errors++;
		if (errors <= 40) $display("mismatch at result %0d: %s", seen, msg);
	endtask
endclass

module set_assoc_writeback_cache_lru_test;
	logic clk = 0;
	logic arst_n = 0;
	longint unsigned cycles = 0;
	cache_scoreboard board;
	logic [ADDR_BITS-1:0] hot [16];

	sacache_req_if req ();
	sacache_rsp_if rsp ();
	sacache_cfg_if cfg ();

	set_assoc_writeback_cache_lru dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
	);

	always #4 clk = ~clk;

	initial begin
		req.valid = 0;
		req.data = '0;
		rsp.ready = 0;
		cfg.valid = 0;
		cfg.index = '0;
		cfg.wdata = '0;
	end

	function automatic int unsigned gap_len();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 45) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// timeout watch
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("status: fail");
			$finish;
		end
	end

	// result side: random stalls, check every beat
	initial begin
		int unsigned g;
		wait (arst_n);
		forever begin
			g = ($urandom_range(0, 9) < 3) ? 0 : gap_len();
			if (g != 0) begin
				rsp.ready <= 0;
				repeat (g) @(posedge clk);
			end
			rsp.ready <= 1;
			@(posedge clk);
			while (!rsp.valid) @(posedge clk);
			board.check_result(rsp.data);
		end
	end

	// valid stays high into a back-to-back beat and drops only before a gap
	task automatic send_item(req_t it);
		int unsigned g;
		g = gap_len();
		if (g != 0) begin
			req.valid <= 0;
			repeat (g) @(posedge clk);
		end
		req.valid <= 1;
		req.data <= it;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		board.note_item(it);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [3:0] val);
		cfg.valid <= 1;
		cfg.index <= idx;
		cfg.wdata <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		board.write_reg(idx, val);
	endtask

	task automatic drain();
		req.valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic access_beat(logic [47:0] a, bit wr, bit eok, bit fok);
		req_t it;
		it = '0;
		it.address = a;
		it.is_write = wr;
		it.lower_evict_ok = eok;
		it.lower_fill_ok = fok;
		send_item(it);
	endtask

	task automatic release_beat(logic [7:0] s);
		req_t it;
		it = '0;
		it.command = 1;
		it.release_set = s;
		it.address = 48'({$urandom, $urandom});
		it.is_write = 1'($urandom_range(0, 1));
		send_item(it);
	endtask

	// random traffic over a small pool of hot blocks plus noise
	task automatic random_phase(int unsigned count);
		logic [47:0] a;
		int unsigned p;
		for (int i = 0; i < 16; i++) hot[i] = 48'({$urandom, $urandom});
		for (int k = 0; k < count; k++) begin
			p = $urandom_range(0, 99);
			if (p < 30) begin
				release_beat((p < 3) ? 8'($urandom) : 8'(hot[$urandom_range(0, 15)] >>
					board.off_r));
			end else begin
				a = (p < 88) ? hot[$urandom_range(0, 15)] ^ 48'($urandom_range(0, 63))
					: 48'({$urandom, $urandom});
				access_beat(a, 1'($urandom_range(0, 1)), $urandom_range(0, 9) < 8,
					$urandom_range(0, 9) < 8);
			end
		end
		drain();
	endtask

	task automatic set_geometry(int unsigned o, int unsigned ix, int unsigned w);
		write_reg(REG_OFFSET, 4'(o));
		write_reg(REG_INDEX, 4'(ix));
		write_reg(REG_WAYS, 4'(w));
		cfg.valid <= 0;
	endtask

	initial begin
		board = new();
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: fills, hits, evictions, refusals, busy set, releases
		set_geometry(6, 2, 2);
		access_beat(48'h0, 0, 1, 1);
		access_beat(48'h0, 1, 1, 1);
		release_beat(8'd0);
		access_beat(48'h0, 1, 1, 1);
		access_beat(48'h100, 1, 1, 1);
		release_beat(8'd0);
		access_beat(48'h200, 0, 0, 1);
		access_beat(48'h200, 0, 1, 0);
		access_beat(48'h200, 1, 1, 1);
		release_beat(8'd0);
		access_beat(48'hFFFF_FFFF_FFFF, 1, 1, 1);
		release_beat(8'hFF);
		release_beat(8'd3);
		access_beat(48'hFFFF_FFFF_FFC0, 0, 1, 1);
		access_beat(48'h0, 0, 1, 1);
		drain();

		set_geometry(15, 15, 15);
		access_beat(48'hAAAA_5555_AAAA, 1, 1, 1);
		release_beat(8'hAA);
		access_beat(48'hAAAA_5555_AAAA, 0, 1, 1);
		drain();
		set_geometry(0, 0, 0);
		access_beat(48'h1, 1, 1, 1);
		access_beat(48'h2, 1, 1, 1);
		release_beat(8'd0);
		access_beat(48'h2, 0, 1, 1);
		drain();

		// random phases across geometries
		set_geometry(0, 0, 1);
		random_phase(200);
		set_geometry(6, 3, 4);
		random_phase(400);
		set_geometry(12, 8, 8);
		random_phase(300);
		set_geometry(4, 1, 8);
		random_phase(400);
		set_geometry(13, 9, 9);
		random_phase(250);
		set_geometry(2, 2, 3);
		random_phase(300);

		drain();
		if (board.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
